[hw/rtl/pts_pkg.sv]
package pts_pkg;

    // Field widths
    localparam int CH_W     = 2;
    localparam int RAW_W    = 8;
    localparam int LEVEL_W  = 7;
    localparam int FILT_W   = 14;

    // Number of filter channels held in the store
    localparam int CHANNELS = 4;

    // Taper breakpoints and scaling
    localparam int TAPER_KNEE     = 50;
    localparam int TAPER_KNEE_OUT = 67;
    localparam int TAPER_UPPER    = 33;
    localparam int TAPER_SPAN     = 205;
    localparam int PERCENT        = 100;
    localparam int SMOOTH_SHIFT   = 2;

    // Full-scale snap
    localparam logic [RAW_W-1:0]   RAW_FULL   = 8'd255;
    localparam logic [LEVEL_W-1:0] LEVEL_SNAP = 7'd99;
    localparam logic [LEVEL_W-1:0] LEVEL_FULL = 7'd100;

    // Divide by 100 as multiply by reciprocal: exact for values below 43690
    localparam int DIV_SHIFT = 20;
    localparam int DIV_MUL_W = 14;
    localparam logic [DIV_MUL_W-1:0] DIV_MUL = 14'd10486;

    localparam logic [FILT_W-1:0] TARGET_MAX = 14'd10000;

    typedef logic [FILT_W-1:0] target_tab_t [2**RAW_W];

    // Build raw sample -> target (taper times 100) at elaboration
    function automatic target_tab_t build_target_tab();
        target_tab_t tab;
        int          t;
        for (int i = 0; i < 2**RAW_W; i++)
        begin
            if (i <= TAPER_KNEE)
                t = (i * TAPER_KNEE_OUT) / TAPER_KNEE;
            else
                t = TAPER_KNEE_OUT + ((i - TAPER_KNEE) * TAPER_UPPER) / TAPER_SPAN;
            tab[i] = FILT_W'(t * PERCENT);
        end
        return tab;
    endfunction

    localparam target_tab_t TARGET_TAB = build_target_tab();

endpackage

[hw/rtl/pot_taper_smoother_unit.sv]
// Channel   Direction  Handshake                      Fields
// sample    receive    sample_valid / sample_stall    channel, raw_sample
// level     send       level_valid / level_stall      channel_out, level
//
// One word per cycle unless stalled; words pass stage one, then the output register.
// Stage one updates the channel's filter value at the accept edge, stage two divides by 100.
// rst_n clears the four filter values and both stage valid bits at once.
// A stall on the level side fills stage one first; sample_stall rises only when both are full.
module pot_taper_smoother_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        sample_valid,
    output logic                        sample_stall,
    input  logic [pts_pkg::CH_W-1:0]    channel,
    input  logic [pts_pkg::RAW_W-1:0]   raw_sample,
    output logic                        level_valid,
    input  logic                        level_stall,
    output logic [pts_pkg::CH_W-1:0]    channel_out,
    output logic [pts_pkg::LEVEL_W-1:0] level
);

    localparam int FW = pts_pkg::FILT_W;

    logic [FW-1:0]               filt_reg [pts_pkg::CHANNELS];
    logic                        s1_valid_reg;
    logic [pts_pkg::CH_W-1:0]    s1_ch_reg;
    logic [FW-1:0]               s1_filt_reg;
    logic                        s1_full_reg;
    logic                        s1_range_reg;
    logic                        out_valid_reg;
    logic [pts_pkg::CH_W-1:0]    out_ch_reg;
    logic [pts_pkg::LEVEL_W-1:0] out_level_reg;

    logic                        s2_en;
    logic                        s1_en;
    logic                        accept;
    logic                        in_range;
    logic [FW-1:0]               target;
    logic [FW-1:0]               cur;
    logic [FW-1:0]               filt_next;
    logic [pts_pkg::LEVEL_W-1:0] level_next;

    // Advance each stage when the one after it can take the word
    assign s2_en        = !out_valid_reg || !level_stall;
    assign s1_en        = !s1_valid_reg || s2_en;
    assign sample_stall = !s1_en;
    assign accept       = sample_valid && s1_en;

    // Look up target and current filter value
    assign in_range = int'(channel) < pts_pkg::CHANNELS;
    assign target   = pts_pkg::TARGET_TAB[raw_sample];
    assign cur      = in_range ? filt_reg[channel] : '0;

    // Move a quarter of the way toward the target, truncating either way
    always_comb
    begin
        if (target > cur)
            filt_next = cur + ((target - cur) >> pts_pkg::SMOOTH_SHIFT);
        else
            filt_next = cur - ((cur - target) >> pts_pkg::SMOOTH_SHIFT);
    end

    // Write back the channel's filter value on accept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pts_pkg::CHANNELS; i++)
                filt_reg[i] <= '0;
        end
        else if (accept && in_range)
        begin
            filt_reg[channel] <= filt_next;
        end
    end

    // Stage one valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_en)
            s1_valid_reg <= sample_valid;
    end

    // Stage one payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ch_reg    <= channel;
            s1_filt_reg  <= filt_next;
            s1_full_reg  <= (raw_sample == pts_pkg::RAW_FULL);
            s1_range_reg <= in_range;
        end
    end

    pts_level u_level (
        .filt     (s1_filt_reg),
        .raw_full (s1_full_reg),
        .in_range (s1_range_reg),
        .level    (level_next)
    );

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s2_en)
            out_valid_reg <= s1_valid_reg;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (s2_en && s1_valid_reg)
        begin
            out_ch_reg    <= s1_ch_reg;
            out_level_reg <= level_next;
        end
    end

    assign level_valid = out_valid_reg;
    assign channel_out = out_ch_reg;
    assign level       = out_level_reg;

    // Input stalls only with both stages holding words
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with a free stage");

    // Filter value stays within the target range
    a_filt_range: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (s1_filt_reg <= pts_pkg::TARGET_MAX))
        else $error("filter value above full scale");

    // Stage one carries the value just written to the store
    a_store_match: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_range) |=> (s1_filt_reg == filt_reg[s1_ch_reg]))
        else $error("stage one disagrees with filter store");

    // Level never exceeds full scale
    a_level_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_level_reg <= pts_pkg::LEVEL_FULL))
        else $error("level above 100");

endmodule

[hw/rtl/pts_level.sv]
module pts_level (
    input  logic [pts_pkg::FILT_W-1:0]  filt,
    input  logic                        raw_full,
    input  logic                        in_range,
    output logic [pts_pkg::LEVEL_W-1:0] level
);

    localparam int PROD_W = pts_pkg::FILT_W + pts_pkg::DIV_MUL_W;

    logic [PROD_W-1:0]           prod;
    logic [pts_pkg::LEVEL_W-1:0] quot;

    // Divide the filter value by 100 through the reciprocal
    assign prod = PROD_W'(filt) * PROD_W'(pts_pkg::DIV_MUL);
    assign quot = prod[pts_pkg::DIV_SHIFT +: pts_pkg::LEVEL_W];

    // Snap to full scale at the top of the pot; drop unknown channels to zero
    always_comb
    begin
        if (!in_range)
            level = '0;
        else if (raw_full && quot == pts_pkg::LEVEL_SNAP)
            level = pts_pkg::LEVEL_FULL;
        else
            level = quot;
    end

endmodule
